/* design/ckpc_pkg.sv */
`default_nettype none

package ckpc_pkg;

    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_LETTER = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] CFG_CIRCULAR = 2'd0;
    localparam logic [1:0] CFG_BOTH     = 2'd1;
    localparam logic [1:0] CFG_QUORUM   = 2'd2;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    localparam int EPOCH_W = 8;

    typedef struct packed {
        logic       bad;
        logic [1:0] base;
    } t_code;

    typedef struct packed {
        logic shift;
        logic clear;
        logic both;
    } t_win_ctrl;

    function automatic t_code encode_letter(input logic [7:0] ch);
        t_code c;
        c.bad  = 1'b0;
        c.base = 2'd0;
        unique case (ch)
            CHAR_A: c.base = 2'd0;
            CHAR_C: c.base = 2'd1;
            CHAR_G: c.base = 2'd2;
            CHAR_T: c.base = 2'd3;
            default: c.bad = 1'b1;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/ckpc_window.sv */
`default_nettype none

module ckpc_window
    import ckpc_pkg::*;
#(
    parameter int WORD_LEN = 8
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  t_win_ctrl                       i_ctrl,
    input  t_code                           i_code,
    output logic [2*WORD_LEN-1:0]           o_next_canon,
    output logic                            o_next_ok,
    output logic [$clog2(WORD_LEN+1)-1:0]   o_seen
);

    localparam int AW = 2 * WORD_LEN;
    localparam int SW = $clog2(WORD_LEN + 1);

    logic [AW-1:0]       r_fwd, n_fwd;
    logic [AW-1:0]       r_rev, n_rev;
    logic [WORD_LEN-1:0] r_mask, n_mask;
    logic [SW-1:0]       r_seen, n_seen;

    always_comb begin
        n_fwd  = {r_fwd[AW-3:0], i_code.base};
        n_rev  = {~i_code.base, r_rev[AW-1:2]};
        n_mask = {r_mask[WORD_LEN-2:0], i_code.bad};
        n_seen = (r_seen == SW'(WORD_LEN)) ? r_seen : r_seen + SW'(1);
        o_next_ok = (n_seen == SW'(WORD_LEN)) && (n_mask == '0);
        o_next_canon = (i_ctrl.both && (n_rev < n_fwd)) ? n_rev : n_fwd;
    end

    assign o_seen = r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_fwd  <= '0;
            r_rev  <= '0;
            r_mask <= '0;
            r_seen <= '0;
        end else if (i_ctrl.shift) begin
            r_fwd  <= n_fwd;
            r_rev  <= n_rev;
            r_mask <= n_mask;
            r_seen <= n_seen;
        end
    end

endmodule

`default_nettype wire

/* design/canonical_kmer_presence_counter.sv */
`default_nettype none
// A letter, read, begin or plain end is accepted in S_IDLE and its result is registered from
// S_RESULT once the output is free, with the count memory read-modify-write; no new item is taken
// before then. A circular end replays the head letters through S_REPLAY and S_RMW, each with a count
// memory update, and registers only the last replayed word's result from S_RESULT.
// After reset a sweep of all 2**(2*WORD_LEN) addresses clears both memories before items are taken;
// every 255th begin triggers a sweep of all addresses of the seen memory only.

module canonical_kmer_presence_counter
    import ckpc_pkg::*;
#(
    parameter int WORD_LEN    = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_op,
    input  wire  [7:0]  i_letter,
    input  wire  [15:0] i_word_index,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [15:0] o_canonical_word,
    output logic        o_word_valid,
    output logic        o_newly_counted,
    output logic [31:0] o_word_count,
    output logic [16:0] o_quorum_words,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [30:0] i_cfg_data
);

    localparam int AW       = 2 * WORD_LEN;
    localparam int HEAD_LEN = WORD_LEN - 1;
    localparam int HW       = (HEAD_LEN > 1) ? $clog2(HEAD_LEN) : 1;
    localparam int SW       = $clog2(WORD_LEN + 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RESULT = 3'd2;
    localparam logic [2:0] S_REPLAY = 3'd3;
    localparam logic [2:0] S_RMW    = 3'd4;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    logic [COUNT_WIDTH-1:0] r_count_mem [0:{AW{1'b1}}];
    logic [EPOCH_W-1:0]     r_seen_mem  [0:{AW{1'b1}}];
    t_code                  r_head      [HEAD_LEN];

    logic [2:0]             r_state, n_state;
    logic                   r_circ, r_both;
    logic [30:0]            r_quorum;
    logic [EPOCH_W-1:0]     r_epoch, n_epoch;
    logic                   r_sweep, n_sweep;
    logic                   r_clr_cnt, n_clr_cnt;
    logic [AW-1:0]          r_clr_addr, n_clr_addr;
    logic [1:0]             r_kind, n_kind;
    logic                   r_hit, n_hit;
    logic [AW-1:0]          r_addr, n_addr;
    logic [15:0]            r_rd_index, n_rd_index;
    logic                   r_clear_after, n_clear_after;
    logic [HW-1:0]          r_rep, n_rep;
    logic [16:0]            r_tally, n_tally;
    logic [COUNT_WIDTH-1:0] r_cnt_rd;
    logic [EPOCH_W-1:0]     r_seen_rd;

    logic                   n_out_valid;
    logic [15:0]            n_canonical_word;
    logic                   n_word_valid, n_newly_counted;
    logic [31:0]            n_word_count;
    logic [16:0]            n_quorum_words;

    t_win_ctrl              win_ctrl;
    t_code                  win_code;
    t_code                  in_code;
    logic [AW-1:0]          win_canon;
    logic                   win_ok;
    logic [SW-1:0]          win_seen;

    logic                   accept, out_free, out_load, do_update;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   cnt_we, seen_we;
    logic [AW-1:0]          wr_addr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic [EPOCH_W-1:0]     seen_wdata;
    logic                   head_we;

    logic                   was_seen, not_sat, tally_hit;
    logic [COUNT_WIDTH-1:0] cnt_inc, cnt_after;
    logic [30:0]            quorum_eff;
    logic [31:0]            addr32;

    ckpc_window #(
        .WORD_LEN (WORD_LEN)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (win_ctrl),
        .i_code       (win_code),
        .o_next_canon (win_canon),
        .o_next_ok    (win_ok),
        .o_seen       (win_seen)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !o_out_valid || !i_out_stall;
    assign in_code     = encode_letter(i_letter);
    assign head_we     = accept && (i_op == OP_LETTER) && (win_seen < SW'(HEAD_LEN));

    always_comb begin
        quorum_eff = (r_quorum == '0) ? 31'd1 : r_quorum;
        was_seen   = (r_seen_rd == r_epoch);
        not_sat    = (r_cnt_rd != '1);
        cnt_inc    = r_cnt_rd + COUNT_WIDTH'(1);
        cnt_after  = (!was_seen && not_sat) ? cnt_inc : r_cnt_rd;
        tally_hit  = !was_seen && not_sat &&
                     ((33'(r_cnt_rd) + 33'd1) == 33'(quorum_eff));
        addr32     = 32'(r_addr);
    end

    always_comb begin
        n_state       = r_state;
        n_epoch       = r_epoch;
        n_sweep       = r_sweep;
        n_clr_cnt     = r_clr_cnt;
        n_clr_addr    = r_clr_addr;
        n_kind        = r_kind;
        n_hit         = r_hit;
        n_addr        = r_addr;
        n_rd_index    = r_rd_index;
        n_clear_after = r_clear_after;
        n_rep         = r_rep;
        win_ctrl.shift = 1'b0;
        win_ctrl.clear = 1'b0;
        win_ctrl.both  = r_both;
        win_code      = in_code;
        rd_en         = 1'b0;
        rd_addr       = win_canon;
        out_load      = 1'b0;
        do_update     = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_hit         = 1'b0;
                    n_kind        = KIND_NONE;
                    n_clear_after = 1'b0;
                    n_state       = S_RESULT;
                    unique case (i_op)
                        OP_BEGIN: begin
                            win_ctrl.clear = 1'b1;
                            if (&r_epoch) begin
                                n_epoch = EPOCH_W'(1);
                                n_sweep = 1'b1;
                            end else begin
                                n_epoch = r_epoch + EPOCH_W'(1);
                            end
                        end
                        OP_LETTER: begin
                            win_ctrl.shift = 1'b1;
                            n_kind = KIND_WORD;
                            n_hit  = win_ok;
                            n_addr = win_canon;
                            rd_en  = win_ok;
                        end
                        OP_END: begin
                            if (r_circ && (win_seen >= SW'(WORD_LEN))) begin
                                n_rep   = '0;
                                n_state = S_REPLAY;
                            end else begin
                                win_ctrl.clear = 1'b1;
                            end
                        end
                        OP_READ: begin
                            n_kind     = KIND_READ;
                            n_rd_index = i_word_index;
                            rd_addr    = AW'(i_word_index);
                            rd_en      = 1'b1;
                        end
                        default: n_kind = KIND_NONE;
                    endcase
                end
            end
            S_REPLAY: begin
                win_code       = r_head[r_rep];
                win_ctrl.shift = 1'b1;
                n_kind = KIND_WORD;
                n_hit  = win_ok;
                n_addr = win_canon;
                rd_en  = win_ok;
                if (r_rep == HW'(HEAD_LEN - 1)) begin
                    n_clear_after = 1'b1;
                    n_state       = S_RESULT;
                end else begin
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                do_update = r_hit;
                n_rep     = r_rep + HW'(1);
                n_state   = S_REPLAY;
            end
            S_RESULT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    do_update = r_hit;
                    if (r_clear_after) begin
                        win_ctrl.clear = 1'b1;
                        n_clear_after  = 1'b0;
                    end
                    if (r_sweep) begin
                        n_sweep    = 1'b0;
                        n_clr_cnt  = 1'b0;
                        n_clr_addr = '0;
                        n_state    = S_CLEAR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            seen_we    = 1'b1;
            cnt_we     = r_clr_cnt;
            wr_addr    = r_clr_addr;
            seen_wdata = '0;
            cnt_wdata  = '0;
        end else begin
            seen_we    = do_update && !was_seen;
            cnt_we     = do_update && !was_seen && not_sat;
            wr_addr    = r_addr;
            seen_wdata = r_epoch;
            cnt_wdata  = cnt_inc;
        end
        n_tally = r_tally + 17'(do_update && tally_hit);
    end

    always_comb begin
        n_out_valid      = o_out_valid && i_out_stall;
        n_canonical_word = o_canonical_word;
        n_word_valid     = o_word_valid;
        n_newly_counted  = o_newly_counted;
        n_word_count     = o_word_count;
        n_quorum_words   = o_quorum_words;
        if (out_load) begin
            n_out_valid      = 1'b1;
            n_canonical_word = '0;
            n_word_valid     = 1'b0;
            n_newly_counted  = 1'b0;
            n_word_count     = '0;
            n_quorum_words   = n_tally;
            if (r_kind == KIND_WORD && r_hit) begin
                n_canonical_word = addr32[15:0];
                n_word_valid     = 1'b1;
                n_newly_counted  = !was_seen;
                n_word_count     = 32'(cnt_after);
            end else if (r_kind == KIND_READ) begin
                n_canonical_word = r_rd_index;
                n_word_count     = 32'(r_cnt_rd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_count_mem[wr_addr] <= cnt_wdata;
        end
        if (rd_en) begin
            r_cnt_rd <= r_count_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (seen_we) begin
            r_seen_mem[wr_addr] <= seen_wdata;
        end
        if (rd_en) begin
            r_seen_rd <= r_seen_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head[win_seen[HW-1:0]] <= in_code;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr           <= n_addr;
        r_rd_index       <= n_rd_index;
        r_rep            <= n_rep;
        o_canonical_word <= n_canonical_word;
        o_word_valid     <= n_word_valid;
        o_newly_counted  <= n_newly_counted;
        o_word_count     <= n_word_count;
        o_quorum_words   <= n_quorum_words;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_epoch       <= EPOCH_W'(1);
            r_sweep       <= 1'b0;
            r_clr_cnt     <= 1'b1;
            r_clr_addr    <= '0;
            r_kind        <= KIND_NONE;
            r_hit         <= 1'b0;
            r_clear_after <= 1'b0;
            r_tally       <= '0;
            o_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_epoch       <= n_epoch;
            r_sweep       <= n_sweep;
            r_clr_cnt     <= n_clr_cnt;
            r_clr_addr    <= n_clr_addr;
            r_kind        <= n_kind;
            r_hit         <= n_hit;
            r_clear_after <= n_clear_after;
            r_tally       <= n_tally;
            o_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circ   <= 1'b0;
            r_both   <= 1'b1;
            r_quorum <= 31'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CIRCULAR: r_circ   <= i_cfg_data[0];
                CFG_BOTH:     r_both   <= i_cfg_data[0];
                CFG_QUORUM:   r_quorum <= i_cfg_data;
                default:      r_quorum <= r_quorum;
            endcase
        end
    end

endmodule

`default_nettype wire
